// ----- design/multidim_array_address_gen_unit_assert.svh -----
// assertion macros used by the checker file
`ifndef MULTIDIM_ARRAY_ADDRESS_GEN_UNIT_ASSERT_SVH
`define MULTIDIM_ARRAY_ADDRESS_GEN_UNIT_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define MDAAG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when ante holds, cons must hold in the next cycle
`define MDAAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mdaag_pkg.sv -----
// ----------------------------------------------------------------------------
// mdaag_pkg
// shared constants and types of the array address generator
// ----------------------------------------------------------------------------
`default_nettype none

package mdaag_pkg;

    // descriptor table geometry
    localparam int MAX_ARRAYS = 16;
    localparam int MAX_DIMS   = 10;
    localparam int ID_W       = 4;   // array id width, MAX_ARRAYS == 2**ID_W
    localparam int DIM_W      = 4;
    localparam int SLOT_W     = $clog2(MAX_ARRAYS * MAX_DIMS);

    // item function codes
    localparam logic [1:0] FUNC_HEADER = 2'd0;
    localparam logic [1:0] FUNC_BOUND  = 2'd1;
    localparam logic [1:0] FUNC_INDEX  = 2'd2;

    // header table entry
    typedef struct packed {
        logic [31:0] base;
        logic [15:0] size;
        logic [3:0]  dims;
    } hdr_entry_t;

    // per-dimension table entry
    typedef struct packed {
        logic [31:0] lower;
        logic [32:0] extent;
    } dim_entry_t;

endpackage

`default_nettype wire

// ----- design/multidim_array_address_gen_unit.sv -----
// ----------------------------------------------------------------------------
// multidim_array_address_gen_unit
// row-major array address generator over a table of array descriptors
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one item per handshake:
//   func 0 loads an array header, func 1 loads one dimension bound, func 2
//   brings one subscript; the subscript marked last_index closes a query
//   output channel (out_valid / out_stall) carries one item per finished query:
//   the byte address and the array id of the closing subscript
//   header and bound loads never stall the input and the next item may follow at once
//   a subscript is worked in steps (table read, three 32x32 partial products of
//   offset * extent on the one shared multiplier, then the accumulate)
//   the closing subscript then forms base + size * offset, done as two 32-bit
//   partial products on the same multiplier
//   results wait in an output register; the next item is accepted while one
//   waits, and only the last step of a query holds if the register is full
//   reset clears the offset accumulator and the control state; the descriptor
//   memories come up undefined and must be loaded before they are queried
// ----------------------------------------------------------------------------
`default_nettype none

module multidim_array_address_gen_unit
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          func,
    input  wire logic [3:0]          array_id,
    input  wire logic [3:0]          dim_index,
    input  wire logic [31:0]         base_address,
    input  wire logic [15:0]         element_size,
    input  wire logic [3:0]          dim_count,
    input  wire logic signed [31:0]  lower_bound,
    input  wire logic signed [31:0]  upper_bound,
    input  wire logic signed [31:0]  index_value,
    input  wire logic                last_index,
    // output channel
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [63:0]       address,
    output logic [3:0]               query_array
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an item
    localparam logic [2:0] ST_P0   = 3'd1;  // table data in, low x low product
    localparam logic [2:0] ST_P1   = 3'd2;  // low offset x high extent
    localparam logic [2:0] ST_P2   = 3'd3;  // high offset x low extent
    localparam logic [2:0] ST_P3   = 3'd4;  // accumulate into the offset
    localparam logic [2:0] ST_F0   = 3'd5;  // size x low offset
    localparam logic [2:0] ST_F1   = 3'd6;  // size x high offset, add base
    localparam logic [2:0] ST_F2   = 3'd7;  // final sum into output register

    // descriptor memories
    mdaag_pkg::hdr_entry_t hdr_mem [mdaag_pkg::MAX_ARRAYS];
    mdaag_pkg::dim_entry_t dim_mem [mdaag_pkg::MAX_ARRAYS * mdaag_pkg::MAX_DIMS];

    mdaag_pkg::hdr_entry_t hdr_rd_reg;
    mdaag_pkg::dim_entry_t dim_rd_reg;

    logic [2:0]  state_reg, state_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] prod_reg;
    logic [63:0] ext_reg;
    logic [63:0] diff_reg;
    logic [31:0] idx_reg;
    logic        last_reg;
    logic [3:0]  id_reg;
    logic        dim_ok_reg;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] address_reg;
    logic [3:0]  query_array_reg;

    logic                          accept;
    logic                          dim_ok;
    logic [mdaag_pkg::SLOT_W-1:0]  slot;
    logic [32:0]                   extent_wr;
    logic [63:0]                   ext_rd;
    logic [63:0]                   lower_rd;
    logic [31:0]                   mul_a, mul_b;
    logic                          out_load;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // dimension slot and the bound it covers
    assign dim_ok = (dim_index < 4'(mdaag_pkg::MAX_DIMS));
    assign slot   = mdaag_pkg::SLOT_W'(array_id) * mdaag_pkg::SLOT_W'(mdaag_pkg::MAX_DIMS)
                  + mdaag_pkg::SLOT_W'(dim_index);

    // extent = upper - lower + 1 in 33-bit two's complement
    assign extent_wr = {upper_bound[31], upper_bound} - {lower_bound[31], lower_bound}
                     + 33'd1;

    // an out-of-range dimension reads as lower 0, extent 1
    assign ext_rd   = dim_ok_reg ? {{31{dim_rd_reg.extent[32]}}, dim_rd_reg.extent} : 64'd1;
    assign lower_rd = dim_ok_reg ? {{32{dim_rd_reg.lower[31]}}, dim_rd_reg.lower} : 64'd0;

    // memory writes and gated reads, only at an accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (func == mdaag_pkg::FUNC_HEADER)
            begin
                hdr_mem[array_id] <= '{base: base_address, size: element_size,
                                       dims: dim_count};
            end
            if (func == mdaag_pkg::FUNC_BOUND && dim_ok)
            begin
                dim_mem[slot] <= '{lower: lower_bound, extent: extent_wr};
            end
            if (func == mdaag_pkg::FUNC_INDEX)
            begin
                hdr_rd_reg <= hdr_mem[array_id];
                if (dim_ok)
                begin
                    dim_rd_reg <= dim_mem[slot];
                end
            end
        end
    end

    // shared 32x32 multiplier operand select
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            ST_P0:
            begin
                mul_a = acc_reg[31:0];
                mul_b = ext_rd[31:0];
            end
            ST_P1:
            begin
                mul_a = acc_reg[31:0];
                mul_b = ext_reg[63:32];
            end
            ST_P2:
            begin
                mul_a = acc_reg[63:32];
                mul_b = ext_reg[31:0];
            end
            ST_F0:
            begin
                mul_a = acc_reg[31:0];
                mul_b = {16'd0, hdr_rd_reg.size};
            end
            ST_F1, ST_F2:
            begin
                // kept through the final step so the high product survives a hold
                mul_a = acc_reg[63:32];
                mul_b = {16'd0, hdr_rd_reg.size};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == mdaag_pkg::FUNC_INDEX)
                begin
                    state_next = ST_P0;
                end
            end
            ST_P0:
            begin
                state_next = ST_P1;
            end
            ST_P1:
            begin
                sum_next   = prod_reg;
                state_next = ST_P2;
            end
            ST_P2:
            begin
                sum_next   = sum_reg + {prod_reg[31:0], 32'd0};
                state_next = ST_P3;
            end
            ST_P3:
            begin
                acc_next   = sum_reg + {prod_reg[31:0], 32'd0} + diff_reg;
                state_next = last_reg ? ST_F0 : ST_IDLE;
            end
            ST_F0:
            begin
                state_next = ST_F1;
            end
            ST_F1:
            begin
                sum_next   = prod_reg + {32'd0, hdr_rd_reg.base};
                state_next = ST_F2;
            end
            ST_F2:
            begin
                // hold here while a previous result still waits
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    acc_next       = 64'd0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= {32'd0, mul_a} * {32'd0, mul_b};
        sum_reg  <= sum_next;
        if (accept)
        begin
            idx_reg    <= index_value;
            last_reg   <= last_index;
            id_reg     <= array_id;
            dim_ok_reg <= dim_ok;
        end
        if (state_reg == ST_P0)
        begin
            ext_reg  <= ext_rd;
            diff_reg <= {{32{idx_reg[31]}}, idx_reg} - lower_rd;
        end
        if (out_load)
        begin
            address_reg     <= sum_reg + {prod_reg[31:0], 32'd0};
            query_array_reg <= id_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign address     = address_reg;
    assign query_array = query_array_reg;

endmodule

`default_nettype wire

// ----- design/mdaag_checker.sv -----
// ----------------------------------------------------------------------------
// mdaag_checker
// port-level checks of the array address generator
// ----------------------------------------------------------------------------
`default_nettype none

`include "multidim_array_address_gen_unit_assert.svh"

module mdaag_checker
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_stall,
    input  wire logic [1:0]   func,
    input  wire logic         out_valid,
    input  wire logic         out_stall,
    input  wire logic [63:0]  address,
    input  wire logic [3:0]   query_array
);

    // waiting result holds still
    `MDAAG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(address) && $stable(query_array), "result changed while stalled")

    // a subscript keeps the block busy for its computation
    `MDAAG_ASSERT_NEXT(a_index_busy, in_valid && !in_stall && func == mdaag_pkg::FUNC_INDEX, in_stall, "subscript did not occupy the block")

    // loads and reserved codes finish in their own cycle
    `MDAAG_ASSERT_NEXT(a_load_fast, in_valid && !in_stall && func != mdaag_pkg::FUNC_INDEX, !in_stall, "load item stalled the input")

    // a new result only comes out of a busy sequencer
    `MDAAG_ASSERT(a_result_src, $rose(out_valid) |-> $past(in_stall), "result without a query in progress")

endmodule

bind multidim_array_address_gen_unit mdaag_checker u_mdaag_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .address     (address),
    .query_array (query_array)
);

`default_nettype wire
